>>> rtl/core/sfc_pkg.sv
package sfc_pkg;

   // Fixed field widths of the reply format.
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 5;

   // Sync byte that opens every reply (sent twice).
   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

   // Bytes of framing around the payload: two sync, id, length, checksum.
   localparam int FRAME_EXTRA = 5;

   // Byte positions within a reply.
   localparam int POS_SYNC0   = 0;
   localparam int POS_SYNC1   = 1;
   localparam int POS_ID      = 2;
   localparam int POS_LEN     = 3;
   localparam int POS_PAYLOAD = 4;

   // Input item kinds.
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_END  = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_EXPECTED_ID     = 1'b0;
   localparam logic CSR_EXPECTED_LENGTH = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_COUNT  = 2'd1,
      STATUS_HEADER = 2'd2,
      STATUS_CHECK  = 2'd3
   } status_type;

   // One finished reply, handed from the front to the back.
   typedef struct packed {
      status_type       status;
      logic [LEN_W-1:0] len;
   } job_type;

endpackage

>>> rtl/core/sfc_ram.sv
module sfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/sfc_front.sv
module sfc_front #(
   parameter int MAX_PAYLOAD = 16,
   parameter int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_take,
   input  logic                        item_func,
   input  logic [sfc_pkg::BYTE_W-1:0]  item_byte,
   input  logic [sfc_pkg::BYTE_W-1:0]  expected_id,
   input  logic [sfc_pkg::LEN_W-1:0]   expected_length,
   output logic                        store_wr_en,
   output logic [AW-1:0]               store_wr_addr,
   output logic [sfc_pkg::BYTE_W-1:0]  store_wr_data,
   output logic                        job_push,
   output sfc_pkg::job_type            job
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 7);
   localparam int CMP_W = CNT_W + 6;
   localparam logic [CMP_W-1:0] COUNT_CAP = CMP_W'(MAX_PAYLOAD + 6);
   localparam logic [CMP_W-1:0] MAX_P     = CMP_W'(MAX_PAYLOAD);

   logic [CNT_W-1:0]           count_ff, count_in;
   logic [sfc_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic [sfc_pkg::BYTE_W-1:0] check_ff, check_in;
   logic                       header_bad_ff, header_bad_in;

   logic [CMP_W-1:0]     pos, len, off, len_p1, pay_end;
   sfc_pkg::status_type  status;

   assign pos     = CMP_W'(count_ff);
   assign len     = CMP_W'(expected_length);
   assign off     = pos - CMP_W'(sfc_pkg::POS_PAYLOAD);
   assign len_p1  = len + CMP_W'(1);
   assign pay_end = len + CMP_W'(sfc_pkg::POS_PAYLOAD);

   // Verdict of the end checks, in priority order.
   always_comb begin
      if ((len > MAX_P) || (pos >= COUNT_CAP) ||
          (pos != len + CMP_W'(sfc_pkg::FRAME_EXTRA))) begin
         status = sfc_pkg::STATUS_COUNT;
      end else if (header_bad_ff) begin
         status = sfc_pkg::STATUS_HEADER;
      end else if ((~sum_ff) != check_ff) begin
         status = sfc_pkg::STATUS_CHECK;
      end else begin
         status = sfc_pkg::STATUS_OK;
      end
   end

   always_comb begin
      count_in      = count_ff;
      sum_in        = sum_ff;
      check_in      = check_ff;
      header_bad_in = header_bad_ff;
      store_wr_en   = 1'b0;
      store_wr_addr = off[AW-1:0];
      store_wr_data = item_byte;
      job_push      = 1'b0;
      job.status    = status;
      job.len       = expected_length;

      if (item_take) begin
         if (item_func == sfc_pkg::FUNC_END) begin
            job_push      = 1'b1;
            count_in      = '0;
            sum_in        = '0;
            check_in      = '0;
            header_bad_in = 1'b0;
         end else if (pos < COUNT_CAP) begin
            count_in = count_ff + CNT_W'(1);

            if ((pos == CMP_W'(sfc_pkg::POS_SYNC0)) ||
                (pos == CMP_W'(sfc_pkg::POS_SYNC1))) begin
               if (item_byte != sfc_pkg::SYNC_BYTE) begin
                  header_bad_in = 1'b1;
               end
            end else if (pos == CMP_W'(sfc_pkg::POS_ID)) begin
               if (item_byte != expected_id) begin
                  header_bad_in = 1'b1;
               end
            end else if (pos == CMP_W'(sfc_pkg::POS_LEN)) begin
               if (item_byte != len_p1[7:0]) begin
                  header_bad_in = 1'b1;
               end
            end

            if ((pos >= CMP_W'(sfc_pkg::POS_ID)) && (pos < pay_end)) begin
               sum_in = sum_ff + item_byte;
            end

            if ((pos >= CMP_W'(sfc_pkg::POS_PAYLOAD)) && (pos < pay_end) &&
                (off < MAX_P)) begin
               store_wr_en = 1'b1;
            end

            if (pos == pay_end) begin
               check_in = item_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sum_ff        <= '0;
         check_ff      <= '0;
         header_bad_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         check_ff      <= check_in;
         header_bad_ff <= header_bad_in;
      end
   end

endmodule

>>> rtl/core/sfc_job_fifo.sv
module sfc_job_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfc_pkg::job_type push_job,
   input  logic             pop,
   output logic             not_empty,
   output sfc_pkg::job_type head_job
);

   sfc_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             do_push, do_pop;

   assign do_push   = push && (fill_ff != 2'd2);
   assign do_pop    = pop && (fill_ff != 2'd0);
   assign not_empty = (fill_ff != 2'd0);
   assign head_job  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> rtl/core/sfc_back.sv
module sfc_back #(
   parameter int MAX_PAYLOAD = 16,
   parameter int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_avail,
   input  sfc_pkg::job_type            job,
   output logic                        job_pop,
   output logic                        busy,
   output logic                        rd_en,
   output logic [AW-1:0]               rd_addr,
   input  logic [sfc_pkg::BYTE_W-1:0]  rd_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sfc_pkg::BYTE_W-1:0]  rsp_payload_byte,
   output logic                        rsp_payload_valid,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_last
);

   localparam int CW = AW + 6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SHOW
   } state_type;

   state_type                 state_ff;
   logic [AW-1:0]             idx_ff;
   logic [sfc_pkg::LEN_W-1:0] len_ff;
   logic                      pv_ff;
   logic                      last_ff;
   sfc_pkg::status_type       status_ff;

   assign job_pop   = (state_ff == ST_IDLE) && job_avail;
   assign busy      = (state_ff != ST_IDLE);
   assign rd_en     = (state_ff == ST_READ);
   assign rd_addr   = idx_ff;
   assign rsp_valid = (state_ff == ST_SHOW);

   // The RAM output register holds still while a byte is on show.
   assign rsp_payload_byte  = pv_ff ? rd_data : '0;
   assign rsp_payload_valid = pv_ff;
   assign rsp_status        = status_ff;
   assign rsp_last          = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         len_ff    <= '0;
         pv_ff     <= 1'b0;
         last_ff   <= 1'b0;
         status_ff <= sfc_pkg::STATUS_OK;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (job_avail) begin
                  len_ff    <= job.len;
                  idx_ff    <= '0;
                  status_ff <= job.status;
                  if ((job.status != sfc_pkg::STATUS_OK) || (job.len == '0)) begin
                     pv_ff    <= 1'b0;
                     last_ff  <= 1'b1;
                     state_ff <= ST_SHOW;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               pv_ff    <= 1'b1;
               last_ff  <= ((CW'(idx_ff) + CW'(1)) == CW'(len_ff));
               state_ff <= ST_SHOW;
            end
            ST_SHOW: begin
               if (!rsp_stall) begin
                  if (last_ff) begin
                     pv_ff    <= 1'b0;
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + AW'(1);
                     state_ff <= ST_READ;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

>>> rtl/core/servo_status_frame_checker_top.sv
// Servo status frame checker. Reply bytes come in on the req_ channel with
// req_func low, one byte per transfer, and a byte is taken whenever req_stall
// is low. A transfer with req_func high marks the line going idle and closes
// the reply: the block then checks byte count, header/id/length and checksum
// in that order and returns either every payload byte of a good frame, in
// order, with the final one marked by rsp_last, or a single status result
// (rsp_last high, rsp_payload_valid low) for a bad one; a good frame with an
// empty payload also gives a single result. While the results of a reply are
// being delivered, req_stall stays high. Each payload byte is first read
// through the payload store's registered read port and then held on show
// until it is handed over, so the next byte is not read before the one on
// show is taken. Configuration writes on the csr_ channel are always taken
// and must arrive only while the block is idle.
module servo_status_frame_checker_top #(
   parameter int MAX_PAYLOAD = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_last,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   // Configuration registers.
   logic [sfc_pkg::BYTE_W-1:0] expected_id_ff;
   logic [sfc_pkg::LEN_W-1:0]  expected_length_ff;

   logic                       req_take;
   logic                       store_wr_en;
   logic [AW-1:0]              store_wr_addr;
   logic [sfc_pkg::BYTE_W-1:0] store_wr_data;
   logic                       store_rd_en;
   logic [AW-1:0]              store_rd_addr;
   logic [sfc_pkg::BYTE_W-1:0] store_rd_data;
   logic                       job_push;
   sfc_pkg::job_type           push_job;
   logic                       job_pop;
   logic                       job_avail;
   sfc_pkg::job_type           head_job;
   logic                       back_busy;

   // Configuration is a plain register write; it never needs to wait.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff     <= 8'd1;
         expected_length_ff <= 5'd1;
      end else if (csr_valid) begin
         case (csr_index)
            sfc_pkg::CSR_EXPECTED_ID: begin
               expected_id_ff <= csr_data;
            end
            sfc_pkg::CSR_EXPECTED_LENGTH: begin
               expected_length_ff <= csr_data[sfc_pkg::LEN_W-1:0];
            end
            default: begin
               expected_id_ff <= expected_id_ff;
            end
         endcase
      end
   end

   // The front writes the payload store that the back is reading, so new
   // input waits until every queued reply has been fully delivered.
   assign req_stall = job_avail || back_busy;
   assign req_take  = req_valid && !req_stall;

   sfc_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .AW          (AW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .item_take       (req_take),
      .item_func       (req_func),
      .item_byte       (req_rx_byte),
      .expected_id     (expected_id_ff),
      .expected_length (expected_length_ff),
      .store_wr_en     (store_wr_en),
      .store_wr_addr   (store_wr_addr),
      .store_wr_data   (store_wr_data),
      .job_push        (job_push),
      .job             (push_job)
   );

   sfc_ram #(
      .WIDTH (sfc_pkg::BYTE_W),
      .DEPTH (MAX_PAYLOAD),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_en   (store_rd_en),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   // Finished replies wait here until the back end is free.
   sfc_job_fifo u_jobs (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .pop       (job_pop),
      .not_empty (job_avail),
      .head_job  (head_job)
   );

   sfc_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .AW          (AW)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_avail         (job_avail),
      .job               (head_job),
      .job_pop           (job_pop),
      .busy              (back_busy),
      .rd_en             (store_rd_en),
      .rd_addr           (store_rd_addr),
      .rd_data           (store_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

endmodule
